### sv/rbcr_pkg.sv
// ----------------------------------------------------------------------------
// rbcr_pkg
// Shared types, constants and helpers of the run-length bit clock recovery.
// ----------------------------------------------------------------------------
package rbcr_pkg;

    // Port widths
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Field widths
    localparam int STRENGTH_W = 16;
    localparam int WIN_W      = 6;
    localparam int RUN_W      = 8;
    localparam int PERIOD_W   = 13;
    localparam int ESUM_W     = 32;
    localparam int REM_W      = 18;   // signed remainder of the scaled run
    localparam int ERRS_W     = 5;
    localparam int ERR_CNT_W  = 6;    // holds a mismatch count up to 32

    // Loop constants
    localparam logic [RUN_W-1:0]    MAX_RUN      = 8'd255;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 13'd1024;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 13'd8191;
    localparam logic [PERIOD_W-1:0] NOMINAL_RST  = 13'd2048;
    localparam logic [15:0]         CODE_RST     = 16'h543D;
    localparam logic [15:0]         MASK_RST     = 16'hFFFF;
    localparam logic [RUN_W-1:0]    MIN_RUN_RST  = 8'd5;
    localparam int                  SCALE_SHIFT  = 8;   // run * 256
    localparam int                  GAIN_I_SHIFT = 4;   // error_sum / 16
    localparam int                  GAIN_P_SHIFT = 5;   // divide by 32 * n
    localparam int                  VOTE_MIN     = 3;

    // Divider: magnitude of (e + es/16) / 32 fits in 24 bits
    localparam int DIV_W     = 24;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int STEP_W    = DIV_W + 2;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCESS_CODE  = 8'd0,
        REG_ACCESS_MASK  = 8'd1,
        REG_MAX_ERRORS   = 8'd2,
        REG_MIN_RUN      = 8'd3,
        REG_NOMINAL_LEN  = 8'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]         access_code;
        logic [15:0]         access_mask;
        logic [ERRS_W-1:0]   max_code_errors;
        logic [RUN_W-1:0]    min_run;
        logic [PERIOD_W-1:0] nominal_bit_length;
    } cfg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESYNC,
        ST_EMIT,
        ST_ACCUM,
        ST_PREP,
        ST_DIV,
        ST_UPDATE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load_resync;
        logic emit_bit;
        logic accum;
        logic div_start;
        logic div_step;
        logic update;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic change;
        logic short_run;
        logic out_free;
        logic more_bits;
        logic div_last;
    } sts_t;

    // Clamp a signed period candidate into the legal bit length range
    function automatic logic [PERIOD_W-1:0] clamp_period(input logic signed [STEP_W-1:0] p);
        logic [PERIOD_W-1:0] res;
        if (p < $signed({{(STEP_W-PERIOD_W){1'b0}}, PERIOD_MIN})) begin
            res = PERIOD_MIN;
        end else if (p > $signed({{(STEP_W-PERIOD_W){1'b0}}, PERIOD_MAX})) begin
            res = PERIOD_MAX;
        end else begin
            res = p[PERIOD_W-1:0];
        end
        return res;
    endfunction

endpackage

### sv/rbcr_cfg.sv
// ----------------------------------------------------------------------------
// rbcr_cfg
// Configuration register file, written through an index/data channel.
// ----------------------------------------------------------------------------
module rbcr_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbcr_pkg::CFG_DATA_W-1:0] cfg_data,
    output rbcr_pkg::cfg_t                  cfg
);
    import rbcr_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.access_code        <= CODE_RST;
            cfg_reg.access_mask        <= MASK_RST;
            cfg_reg.max_code_errors    <= '0;
            cfg_reg.min_run            <= MIN_RUN_RST;
            cfg_reg.nominal_bit_length <= NOMINAL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ACCESS_CODE: cfg_reg.access_code     <= cfg_data;
                REG_ACCESS_MASK: cfg_reg.access_mask     <= cfg_data;
                REG_MAX_ERRORS:  cfg_reg.max_code_errors <= cfg_data[ERRS_W-1:0];
                REG_MIN_RUN:     cfg_reg.min_run         <= cfg_data[RUN_W-1:0];
                REG_NOMINAL_LEN: cfg_reg.nominal_bit_length <= cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### sv/rbcr_div.sv
// ----------------------------------------------------------------------------
// rbcr_div
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module rbcr_div #(
    parameter int NW = 7
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         step,
    input  logic [rbcr_pkg::DIV_W-1:0]   dividend,
    input  logic [NW-1:0]                divisor,
    output logic [rbcr_pkg::DIV_W-1:0]   quotient,
    output logic                         last
);
    import rbcr_pkg::*;

    logic [DIV_W-1:0]     q_reg;
    logic [NW:0]          r_reg;
    logic [NW-1:0]        dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [NW:0] r_sh;
    logic        fits;

    // Shift in the next dividend bit and try the subtract
    assign r_sh     = {r_reg[NW-1:0], q_reg[DIV_W-1]};
    assign fits     = r_sh >= {1'b0, dsr_reg};
    assign quotient = q_reg;
    assign last     = cnt_reg == DIV_CNT_W'(DIV_W - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= '0;
        end else if (step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            r_reg   <= '0;
            dsr_reg <= divisor;
        end else if (step) begin
            q_reg <= {q_reg[DIV_W-2:0], fits};
            r_reg <= fits ? (r_sh - {1'b0, dsr_reg}) : r_sh;
        end
    end

endmodule

### sv/rbcr_dp.sv
// ----------------------------------------------------------------------------
// rbcr_dp
// Datapath: vote window, run counter, bit slicer, sync compare, PI loop
// and the result register.
// ----------------------------------------------------------------------------
module rbcr_dp #(
    parameter int CODE_WIDTH = 16,
    parameter int MAX_BITS   = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rbcr_pkg::cfg_t                  cfg,
    input  rbcr_pkg::cmd_t                  cmd,
    output rbcr_pkg::sts_t                  sts,
    input  logic                            in_raw_bit,
    input  logic [rbcr_pkg::STRENGTH_W-1:0] in_strength,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_data_bit,
    output logic                            out_sync_hit,
    output logic                            out_resync,
    output logic [rbcr_pkg::STRENGTH_W-1:0] out_strength,
    output logic                            out_last
);
    import rbcr_pkg::*;

    localparam int NW = $clog2(MAX_BITS + 1);
    localparam int CW = CODE_WIDTH;

    // Architectural state
    logic [WIN_W-1:0]         win_reg;
    logic                     lvl_reg;
    logic [RUN_W-1:0]         run_reg;
    logic [PERIOD_W-1:0]      bp_reg;
    logic signed [ESUM_W-1:0] esum_reg;
    logic [CW-1:0]            shift_reg;

    // Per-transition working registers
    logic signed [REM_W-1:0]  rem_reg;
    logic [NW-1:0]            nbits_reg;
    logic [STRENGTH_W-1:0]    strength_reg;
    logic                     neg_reg;

    // Result register
    logic                     out_valid_reg;
    logic                     out_bit_reg;
    logic                     out_sync_reg;
    logic                     out_resync_reg;
    logic [STRENGTH_W-1:0]    out_strength_reg;
    logic                     out_last_reg;

    // Vote over the sample window
    logic [WIN_W-1:0] win_next;
    logic [2:0]       vote_cnt;
    logic             level;

    assign win_next = {win_reg[WIN_W-2:0], in_raw_bit};

    always_comb begin
        vote_cnt = '0;
        for (int i = 0; i < WIN_W; i++) begin
            vote_cnt = vote_cnt + 3'(win_next[i]);
        end
    end

    assign level = vote_cnt >= 3'(VOTE_MIN);

    // Short run test against min_run and half a bit
    logic [PERIOD_W-2:0]      half;
    logic [RUN_W+SCALE_SHIFT-1:0] run_scaled;
    logic signed [REM_W-1:0]  half_s;

    assign half       = bp_reg[PERIOD_W-1:1];
    assign run_scaled = {run_reg, {SCALE_SHIFT{1'b0}}};
    assign half_s     = $signed({{(REM_W-PERIOD_W+1){1'b0}}, half});

    // One bit step of the slicer
    logic signed [REM_W-1:0] rem_dec;
    logic [NW-1:0]           n_inc;
    logic                    bit_val;
    logic [CW-1:0]           shift_nx;

    assign rem_dec  = rem_reg - $signed({{(REM_W-PERIOD_W){1'b0}}, bp_reg});
    assign n_inc    = nbits_reg + 1'b1;
    assign bit_val  = ~lvl_reg;   // level of the run that just ended
    assign shift_nx = {shift_reg[CW-2:0], bit_val};

    // Access code compare over CODE_WIDTH bits
    logic [CW+15:0]        code_ext;
    logic [CW+15:0]        mask_ext;
    logic [CW-1:0]         diff;
    logic [ERR_CNT_W-1:0]  err_cnt;
    logic                  hit;

    assign code_ext = {{CW{1'b0}}, cfg.access_code};
    assign mask_ext = {{CW{1'b0}}, cfg.access_mask};
    assign diff     = (shift_nx & mask_ext[CW-1:0]) ^ code_ext[CW-1:0];

    always_comb begin
        err_cnt = '0;
        for (int i = 0; i < CW; i++) begin
            err_cnt = err_cnt + ERR_CNT_W'(diff[i]);
        end
    end

    assign hit = err_cnt <= {1'b0, cfg.max_code_errors};

    // Integral sum with saturation to 32 bits
    logic signed [ESUM_W:0]   es_wide;
    logic signed [ESUM_W-1:0] es_sat;

    assign es_wide = {esum_reg[ESUM_W-1], esum_reg} +
                     {{(ESUM_W+1-REM_W){rem_reg[REM_W-1]}}, rem_reg};

    always_comb begin
        if (es_wide[ESUM_W] != es_wide[ESUM_W-1]) begin
            es_sat = es_wide[ESUM_W] ? {1'b1, {(ESUM_W-1){1'b0}}}
                                     : {1'b0, {(ESUM_W-1){1'b1}}};
        end else begin
            es_sat = es_wide[ESUM_W-1:0];
        end
    end

    // Dividend: |e + es/16| / 32, both divisions toward zero
    localparam int ESQ_W = ESUM_W - GAIN_I_SHIFT;
    localparam int X_W   = 30;

    logic signed [ESUM_W-1:0] es_adj;
    logic signed [ESQ_W-1:0]  es_q;
    logic signed [X_W-1:0]    x_sum;
    logic [X_W-1:0]           x_mag;
    logic [DIV_W-1:0]         dividend;

    assign es_adj   = esum_reg + (esum_reg[ESUM_W-1] ? 32'sd15 : 32'sd0);
    assign es_q     = es_adj[ESUM_W-1:GAIN_I_SHIFT];
    assign x_sum    = {{(X_W-REM_W){rem_reg[REM_W-1]}}, rem_reg} +
                      {{(X_W-ESQ_W){es_q[ESQ_W-1]}}, es_q};
    assign x_mag    = x_sum[X_W-1] ? (~x_sum + 1'b1) : x_sum;
    assign dividend = x_mag[GAIN_P_SHIFT+DIV_W-1:GAIN_P_SHIFT];

    // Divider by the bit count
    logic [DIV_W-1:0] quotient;
    logic             div_last;

    rbcr_div #(
        .NW (NW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (dividend),
        .divisor  (nbits_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    // Period update with clamp
    logic signed [STEP_W-1:0] step_s;
    logic signed [STEP_W-1:0] bp_sum;

    assign step_s = neg_reg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    assign bp_sum = $signed({{(STEP_W-PERIOD_W){1'b0}}, bp_reg}) + step_s;

    // Status to the controller
    logic out_free;

    assign out_free      = !out_valid_reg || out_ready;
    assign sts.change    = level != lvl_reg;
    assign sts.short_run = (run_reg < cfg.min_run) ||
                           (run_scaled <= {{(RUN_W+SCALE_SHIFT-PERIOD_W+1){1'b0}}, half});
    assign sts.out_free  = out_free;
    assign sts.more_bits = (rem_dec > half_s) && (n_inc < NW'(MAX_BITS));
    assign sts.div_last  = div_last;

    // Architectural state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            lvl_reg   <= 1'b0;
            run_reg   <= '0;
            bp_reg    <= NOMINAL_RST;
            esum_reg  <= '0;
            shift_reg <= '0;
        end else begin
            if (cmd.accept) begin
                if (!sts.change) begin
                    win_reg <= win_next;
                    if (run_reg < MAX_RUN) begin
                        run_reg <= run_reg + 1'b1;
                    end
                end else if (sts.short_run) begin
                    // Resync: clear everything, start a new run
                    win_reg   <= '0;
                    lvl_reg   <= level;
                    run_reg   <= RUN_W'(1);
                    bp_reg    <= clamp_period($signed({{(STEP_W-PERIOD_W){1'b0}},
                                                       cfg.nominal_bit_length}));
                    esum_reg  <= '0;
                    shift_reg <= '0;
                end else begin
                    win_reg <= win_next;
                    lvl_reg <= level;
                    run_reg <= RUN_W'(1);
                end
            end
            if (cmd.emit_bit) begin
                shift_reg <= shift_nx;
            end
            if (cmd.accum) begin
                esum_reg <= es_sat;
            end
            if (cmd.update) begin
                bp_reg <= clamp_period(bp_sum);
            end
        end
    end

    // Working registers of one transition
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rem_reg      <= $signed({{(REM_W-RUN_W-SCALE_SHIFT){1'b0}}, run_scaled});
            nbits_reg    <= '0;
            strength_reg <= in_strength;
        end
        if (cmd.emit_bit) begin
            rem_reg   <= rem_dec;
            nbits_reg <= n_inc;
        end
        if (cmd.div_start) begin
            neg_reg <= x_sum[X_W-1];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_bit || cmd.load_resync) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_resync) begin
            out_bit_reg      <= 1'b0;
            out_sync_reg     <= 1'b0;
            out_resync_reg   <= 1'b1;
            out_strength_reg <= strength_reg;
            out_last_reg     <= 1'b1;
        end else if (cmd.emit_bit) begin
            out_bit_reg      <= bit_val;
            out_sync_reg     <= hit;
            out_resync_reg   <= 1'b0;
            out_strength_reg <= strength_reg;
            out_last_reg     <= !sts.more_bits;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_data_bit = out_bit_reg;
    assign out_sync_hit = out_sync_reg;
    assign out_resync   = out_resync_reg;
    assign out_strength = out_strength_reg;
    assign out_last     = out_last_reg;

endmodule

### sv/rbcr_ctrl.sv
// ----------------------------------------------------------------------------
// rbcr_ctrl
// Controller: sequences accept, bit emission, PI update and resync.
// ----------------------------------------------------------------------------
module rbcr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rbcr_pkg::sts_t sts,
    output rbcr_pkg::cmd_t cmd
);
    import rbcr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && sts.change) begin
                    state_next = sts.short_run ? ST_RESYNC : ST_EMIT;
                end
            end
            ST_RESYNC: begin
                if (sts.out_free) begin
                    cmd.load_resync = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_bit = 1'b1;
                    if (!sts.more_bits) begin
                        state_next = ST_ACCUM;
                    end
                end
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/runlength_bit_clock_recovery.sv
// ----------------------------------------------------------------------------
// runlength_bit_clock_recovery
// Run-length clock and data recovery with a PI-tracked bit length.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sliced sample per transfer (raw_bit, strength).
//   m_axis carries recovered bits; tuser flags a resync result, tlast marks
//   the final result caused by one sample. cfg_* writes the registers by
//   index and is always ready; write it only while the block is idle.
//   Sequence: a sample that keeps the voted level leaves the block idle. A
//   level change that resyncs loads one resync result. A level change that
//   ends a valid run emits n bits, one bit per cycle into the result register
//   while m_axis is free, then runs the integral update, the dividend setup,
//   24 steps of the bit-serial divider by the bit count, and the period update.
//   The first result of a level change is loaded in the emit or resync state.
//   A stalled m_axis holds the result register and pauses bit emission; the
//   sample channel keeps going while a result waits, until the next level
//   change needs the register.
//   Reset (aresetn low, synchronous) loads the register defaults, clears the
//   window, run, integral and shift register and sets the bit length to 2048.
// ----------------------------------------------------------------------------
module runlength_bit_clock_recovery #(
    parameter int CODE_WIDTH = 16,
    parameter int MAX_BITS   = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sample channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rbcr_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // raw_bit, strength[15:0]
    // result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rbcr_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // data_bit, sync_hit, strength_out
    output logic                             m_axis_tuser,  // resync
    output logic                             m_axis_tlast,
    // configuration
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rbcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbcr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rbcr_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    logic                  out_bit;
    logic                  out_sync;
    logic [STRENGTH_W-1:0] out_strength;

    rbcr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rbcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rbcr_dp #(
        .CODE_WIDTH (CODE_WIDTH),
        .MAX_BITS   (MAX_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .in_raw_bit   (s_axis_tdata[0]),
        .in_strength  (s_axis_tdata[STRENGTH_W:1]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data_bit (out_bit),
        .out_sync_hit (out_sync),
        .out_resync   (m_axis_tuser),
        .out_strength (out_strength),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {{(M_TDATA_W-STRENGTH_W-2){1'b0}}, out_strength, out_sync, out_bit};

    // A resync result is always the only and final one, with zero bit fields
    a_resync_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[1:0] == 2'b00))
        else $error("resync result malformed");

    // The result register is loaded only when it is free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_bit || cmd.load_resync) |-> sts.out_free)
        else $error("result register overwritten");

    // The period update follows the final divider step
    a_update_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> $past(cmd.div_step && sts.div_last))
        else $error("period update without finished divide");

    // No sample is taken while a bit, a resync result or a divider step is issued
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_bit || cmd.div_step || cmd.load_resync) |-> !s_axis_tready)
        else $error("sample accepted while busy");

endmodule
